// ===== src/http_request_header_parser_core_assert.svh =====
// assertion macros for the request header parser
`ifndef HTTP_REQUEST_HEADER_PARSER_CORE_ASSERT_SVH
`define HTTP_REQUEST_HEADER_PARSER_CORE_ASSERT_SVH

// condition in the same cycle
`define HRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition in the next cycle
`define HRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hrp_pkg.sv =====
`default_nettype none

package hrp_pkg;

  // result tags
  localparam logic [1:0] TAG_NONE  = 2'd0;
  localparam logic [1:0] TAG_PATH  = 2'd1;
  localparam logic [1:0] TAG_PROTO = 2'd2;
  localparam logic [1:0] TAG_HOST  = 2'd3;

  // method codes
  localparam logic [1:0] METH_NONE = 2'd0;
  localparam logic [1:0] METH_GET  = 2'd1;
  localparam logic [1:0] METH_POST = 2'd2;

  // parse status codes
  localparam logic [1:0] ST_PROGRESS    = 2'd0;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
  localparam logic [1:0] ST_INCOMPLETE  = 2'd2;
  localparam logic [1:0] ST_COMPLETE    = 2'd3;

  // special bytes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0a;

  // length of the held protocol prefix
  localparam int unsigned HOLD_DEPTH = 5;
  localparam logic [2:0]  HOLD_LAST  = 3'(HOLD_DEPTH - 1);

  typedef logic [7:0] byte_t;

  // fold lower case letters to upper case
  function automatic byte_t upcase(input byte_t c);
    if (c >= 8'h61 && c <= 8'h7a) begin
      return byte_t'(c - 8'd32);
    end
    return c;
  endfunction

  // "GET "
  function automatic byte_t get_chr(input logic [2:0] p);
    byte_t r;
    unique case (p)
      3'd0:    r = 8'h47;
      3'd1:    r = 8'h45;
      3'd2:    r = 8'h54;
      3'd3:    r = CH_SPACE;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // "POST "
  function automatic byte_t post_chr(input logic [2:0] p);
    byte_t r;
    unique case (p)
      3'd0:    r = 8'h50;
      3'd1:    r = 8'h4f;
      3'd2:    r = 8'h53;
      3'd3:    r = 8'h54;
      3'd4:    r = CH_SPACE;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // "HTTP/"
  function automatic byte_t http_chr(input logic [2:0] p);
    byte_t r;
    unique case (p)
      3'd0:    r = 8'h48;
      3'd1:    r = 8'h54;
      3'd2:    r = 8'h54;
      3'd3:    r = 8'h50;
      3'd4:    r = 8'h2f;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // "HOST: "
  function automatic byte_t host_chr(input logic [2:0] p);
    byte_t r;
    unique case (p)
      3'd0:    r = 8'h48;
      3'd1:    r = 8'h4f;
      3'd2:    r = 8'h53;
      3'd3:    r = 8'h54;
      3'd4:    r = 8'h3a;
      3'd5:    r = CH_SPACE;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/http_request_header_parser_core.sv =====
// request line and host parser, one byte per item
// a byte passes the input register, then the result register, before its first result shows
// throughput: one byte per cycle while out_stall is low; the byte closing "HTTP/" gives
//   five results, drained in order from the hold by the single result register
// reset: synchronous active low rst_n clears parse state and both valid flags; no clearing pass
`default_nettype none

module http_request_header_parser_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire hrp_pkg::byte_t   in_char_in,
  input  wire logic             in_begin_req,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [1:0]            out_tag,
  output hrp_pkg::byte_t        out_data,
  output logic                  out_field_end,
  output logic [1:0]            out_method,
  output logic [1:0]            out_status,
  output logic                  out_last
);
  import hrp_pkg::*;

  `include "http_request_header_parser_core_assert.svh"

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_PATH,
    PH_PROTO_MATCH,
    PH_PROTO,
    PH_HOST_MATCH,
    PH_HOST,
    PH_DONE
  } phase_t;

  // input register
  logic       in_full_r;
  byte_t      in_char_r;
  logic       in_begin_r;

  // parse state
  phase_t     phase_r, phase_nxt;
  logic [2:0] match_pos_r, match_pos_nxt;
  logic [1:0] cand_r, cand_nxt;
  logic [1:0] method_r, method_nxt;
  logic [1:0] status_r, status_nxt;
  byte_t      prefix_hold_r [HOLD_DEPTH];
  logic       hold_wr;

  // result register
  logic       res_valid_r;
  logic [1:0] res_tag_r, res_tag_nxt;
  byte_t      res_data_r, res_data_nxt;
  logic       res_fend_r, res_fend_nxt;
  logic [1:0] res_method_r;
  logic [1:0] res_status_r;
  logic       res_burst_r, res_burst_nxt;
  logic [2:0] res_idx_r;

  logic       res_last;
  logic       res_take;
  logic       res_free;
  logic       step;
  logic       in_take;

  // handshake
  assign res_last = !res_burst_r || (res_idx_r == HOLD_LAST);
  assign res_take = res_valid_r && !out_stall;
  assign res_free = !res_valid_r || (res_take && res_last);
  assign step     = in_full_r && res_free;
  assign in_stall = in_full_r && !step;
  assign in_take  = in_valid && !in_stall;

  // one parse step on the registered byte
  always_comb begin
    byte_t      u;
    logic [2:0] p;
    logic       g;
    logic       q;
    phase_t     ph;
    u             = upcase(in_char_r);
    ph            = phase_r;
    phase_nxt     = phase_r;
    match_pos_nxt = match_pos_r;
    cand_nxt      = cand_r;
    method_nxt    = method_r;
    status_nxt    = status_r;
    if (in_begin_r) begin
      ph            = PH_METHOD;
      phase_nxt     = PH_METHOD;
      match_pos_nxt = 3'd0;
      cand_nxt      = 2'b11;
      method_nxt    = METH_NONE;
      status_nxt    = ST_PROGRESS;
    end
    p             = match_pos_nxt;
    g             = 1'b0;
    q             = 1'b0;
    hold_wr       = 1'b0;
    res_tag_nxt   = TAG_NONE;
    res_data_nxt  = 8'h00;
    res_fend_nxt  = 1'b0;
    res_burst_nxt = 1'b0;
    unique case (ph)
      PH_METHOD: begin
        g = cand_nxt[0] && (p < 3'd4) && (u == get_chr(p));
        q = cand_nxt[1] && (p < 3'd5) && (u == post_chr(p));
        if (g && p == 3'd3) begin
          method_nxt    = METH_GET;
          phase_nxt     = PH_PATH;
          match_pos_nxt = 3'd0;
        end else if (q && p == 3'd4) begin
          method_nxt    = METH_POST;
          phase_nxt     = PH_PATH;
          match_pos_nxt = 3'd0;
        end else if (!g && !q) begin
          status_nxt = ST_UNSUPPORTED;
          phase_nxt  = PH_DONE;
        end else begin
          cand_nxt      = {q, g};
          match_pos_nxt = 3'(p + 3'd1);
        end
      end
      PH_PATH: begin
        if (in_char_r == CH_SPACE) begin
          phase_nxt     = PH_PROTO_MATCH;
          match_pos_nxt = 3'd0;
          res_fend_nxt  = 1'b1;
        end else begin
          res_tag_nxt  = TAG_PATH;
          res_data_nxt = in_char_r;
        end
      end
      PH_PROTO_MATCH: begin
        if (p < 3'(HOLD_DEPTH) && u == http_chr(p)) begin
          hold_wr = 1'b1;
          if (p == HOLD_LAST) begin
            phase_nxt     = PH_PROTO;
            match_pos_nxt = 3'd0;
            res_burst_nxt = 1'b1;
          end else begin
            match_pos_nxt = 3'(p + 3'd1);
          end
        end else begin
          status_nxt = ST_INCOMPLETE;
          phase_nxt  = PH_DONE;
        end
      end
      PH_PROTO: begin
        if (in_char_r == CH_LF) begin
          phase_nxt     = PH_HOST_MATCH;
          match_pos_nxt = 3'd0;
          res_fend_nxt  = 1'b1;
        end else begin
          res_tag_nxt  = TAG_PROTO;
          res_data_nxt = in_char_r;
        end
      end
      PH_HOST_MATCH: begin
        if (p < 3'd6 && u == host_chr(p)) begin
          if (p == 3'd5) begin
            phase_nxt     = PH_HOST;
            match_pos_nxt = 3'd0;
          end else begin
            match_pos_nxt = 3'(p + 3'd1);
          end
        end else begin
          status_nxt = ST_INCOMPLETE;
          phase_nxt  = PH_DONE;
        end
      end
      PH_HOST: begin
        if (in_char_r == CH_LF) begin
          status_nxt   = ST_COMPLETE;
          phase_nxt    = PH_DONE;
          res_fend_nxt = 1'b1;
        end else begin
          res_tag_nxt  = TAG_HOST;
          res_data_nxt = in_char_r;
        end
      end
      default: begin
      end
    endcase
  end

  // state, input register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      phase_r     <= PH_METHOD;
      match_pos_r <= 3'd0;
      cand_r      <= 2'b11;
      method_r    <= METH_NONE;
      status_r    <= ST_PROGRESS;
      res_valid_r <= 1'b0;
      res_burst_r <= 1'b0;
      res_idx_r   <= 3'd0;
    end else begin
      // input register
      if (in_take) begin
        in_full_r  <= 1'b1;
        in_char_r  <= in_char_in;
        in_begin_r <= in_begin_req;
      end else if (step) begin
        in_full_r <= 1'b0;
      end
      // parse step and result load
      if (step) begin
        phase_r      <= phase_nxt;
        match_pos_r  <= match_pos_nxt;
        cand_r       <= cand_nxt;
        method_r     <= method_nxt;
        status_r     <= status_nxt;
        if (hold_wr) begin
          prefix_hold_r[match_pos_r] <= in_char_r;
        end
        res_valid_r  <= 1'b1;
        res_tag_r    <= res_tag_nxt;
        res_data_r   <= res_data_nxt;
        res_fend_r   <= res_fend_nxt;
        res_method_r <= method_nxt;
        res_status_r <= status_nxt;
        res_burst_r  <= res_burst_nxt;
        res_idx_r    <= 3'd0;
      end else if (res_take) begin
        if (res_last) begin
          res_valid_r <= 1'b0;
          res_burst_r <= 1'b0;
        end else begin
          res_idx_r <= 3'(res_idx_r + 3'd1);
        end
      end
    end
  end

  // result ports, held prefix bytes drained in order
  assign out_valid     = res_valid_r;
  assign out_tag       = res_burst_r ? TAG_PROTO : res_tag_r;
  assign out_data      = res_burst_r ? prefix_hold_r[res_idx_r] : res_data_r;
  assign out_field_end = res_burst_r ? 1'b0 : res_fend_r;
  assign out_method    = res_method_r;
  assign out_status    = res_status_r;
  assign out_last      = res_last;

  // checks
  `HRP_ASSERT_NOW(a_idx_range, res_burst_r, res_idx_r <= HOLD_LAST, "hold index out of range")
  `HRP_ASSERT_NOW(a_none_zero, out_valid && out_tag == TAG_NONE, out_data == 8'h00,
                  "untagged result carries data")
  `HRP_ASSERT_NOW(a_done_method, out_valid && out_status == ST_COMPLETE,
                  out_method != METH_NONE, "complete header without method")
  `HRP_ASSERT_NEXT(a_burst_cont, out_valid && !out_stall && !out_last,
                   out_valid && out_tag == TAG_PROTO, "protocol burst broken")

endmodule

`default_nettype wire

// ===== tb/tb_http_request_header_parser_core.sv =====
`default_nettype none

module tb_http_request_header_parser_core;
  import hrp_pkg::*;

  localparam byte_t CH_CR = 8'h0d;

  // keywords, right aligned, first character in the highest byte
  localparam logic [47:0] W_GET  = "GET ";
  localparam logic [47:0] W_POST = "POST ";
  localparam logic [47:0] W_HTTP = "HTTP/";
  localparam logic [47:0] W_HOST = "HOST: ";

  typedef enum logic [2:0] {
    AT_METHOD, AT_PATH, AT_PROTO_PREFIX, AT_PROTO, AT_HOST_PREFIX, AT_HOST, AT_FINISHED
  } parse_phase_t;

  typedef struct {
    byte_t ch;
    logic  first;
    bit    sync_before;
  } header_byte_t;

  typedef struct {
    logic [1:0] tag;
    byte_t      data;
    logic       fend;
    logic [1:0] meth;
    logic [1:0] stat;
    logic       last;
  } parse_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  byte_t      in_char_in = 8'h00;
  logic       in_begin_req = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_tag;
  byte_t      out_data;
  logic       out_field_end;
  logic [1:0] out_method;
  logic [1:0] out_status;
  logic       out_last;

  http_request_header_parser_core i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_in   (in_char_in),
    .in_begin_req (in_begin_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_tag      (out_tag),
    .out_data     (out_data),
    .out_field_end(out_field_end),
    .out_method   (out_method),
    .out_status   (out_status),
    .out_last     (out_last)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  header_byte_t  pending_bytes[$];
  parse_result_t results_due_q[$];
  byte_t         frame[$];

  int results_due = 0;
  int results_seen = 0;
  int items_taken = 0;
  int mismatches = 0;
  int n_complete = 0;
  int n_unsupported = 0;
  int n_incomplete = 0;
  logic quiet_tail = 1'b0;

  // parser state mirror
  parse_phase_t parse_at;
  int           match_idx;
  logic [1:0]   cand;
  byte_t        held[5];
  logic [1:0]   meth_now;
  logic [1:0]   stat_now;

  function automatic byte_t word_at(input logic [47:0] w, input int len, input int p);
    if (p >= len) return 8'h00;
    return w[8*(len-1-p) +: 8];
  endfunction

  function automatic void expect_result(input logic [1:0] tag, input byte_t data,
                                        input logic fend, input logic last);
    results_due_q.push_back('{tag, data, fend, meth_now, stat_now, last});
    results_due++;
  endfunction

  // expected results for one accepted header byte
  task automatic parse_header_byte(input byte_t c, input logic restart);
    byte_t u;
    bit    g;
    bit    q;
    u = (c >= 8'h61 && c <= 8'h7a) ? byte_t'(c - 8'd32) : c;
    if (restart) begin
      parse_at = AT_METHOD;
      match_idx = 0;
      cand = 2'b11;
      meth_now = METH_NONE;
      stat_now = ST_PROGRESS;
    end
    case (parse_at)
      AT_METHOD: begin
        g = cand[0] && match_idx < 4 && u == word_at(W_GET, 4, match_idx);
        q = cand[1] && match_idx < 5 && u == word_at(W_POST, 5, match_idx);
        if (g && match_idx == 3) begin
          meth_now = METH_GET;
          parse_at = AT_PATH;
          match_idx = 0;
        end else if (q && match_idx == 4) begin
          meth_now = METH_POST;
          parse_at = AT_PATH;
          match_idx = 0;
        end else if (!g && !q) begin
          stat_now = ST_UNSUPPORTED;
          parse_at = AT_FINISHED;
          n_unsupported++;
        end else begin
          cand = {q, g};
          match_idx++;
        end
        expect_result(TAG_NONE, 8'h00, 1'b0, 1'b1);
      end
      AT_PATH: begin
        if (c == CH_SPACE) begin
          parse_at = AT_PROTO_PREFIX;
          match_idx = 0;
          expect_result(TAG_NONE, 8'h00, 1'b1, 1'b1);
        end else begin
          expect_result(TAG_PATH, c, 1'b0, 1'b1);
        end
      end
      AT_PROTO_PREFIX: begin
        if (match_idx < 5 && u == word_at(W_HTTP, 5, match_idx)) begin
          held[match_idx] = c;
          if (match_idx == 4) begin
            // whole prefix seen, release the held bytes
            parse_at = AT_PROTO;
            match_idx = 0;
            for (int k = 0; k < 5; k++) expect_result(TAG_PROTO, held[k], 1'b0, k == 4);
          end else begin
            match_idx++;
            expect_result(TAG_NONE, 8'h00, 1'b0, 1'b1);
          end
        end else begin
          stat_now = ST_INCOMPLETE;
          parse_at = AT_FINISHED;
          n_incomplete++;
          expect_result(TAG_NONE, 8'h00, 1'b0, 1'b1);
        end
      end
      AT_PROTO: begin
        if (c == CH_LF) begin
          parse_at = AT_HOST_PREFIX;
          match_idx = 0;
          expect_result(TAG_NONE, 8'h00, 1'b1, 1'b1);
        end else begin
          expect_result(TAG_PROTO, c, 1'b0, 1'b1);
        end
      end
      AT_HOST_PREFIX: begin
        if (match_idx < 6 && u == word_at(W_HOST, 6, match_idx)) begin
          if (match_idx == 5) begin
            parse_at = AT_HOST;
            match_idx = 0;
          end else begin
            match_idx++;
          end
        end else begin
          stat_now = ST_INCOMPLETE;
          parse_at = AT_FINISHED;
          n_incomplete++;
        end
        expect_result(TAG_NONE, 8'h00, 1'b0, 1'b1);
      end
      AT_HOST: begin
        if (c == CH_LF) begin
          stat_now = ST_COMPLETE;
          parse_at = AT_FINISHED;
          n_complete++;
          expect_result(TAG_NONE, 8'h00, 1'b1, 1'b1);
        end else begin
          expect_result(TAG_HOST, c, 1'b0, 1'b1);
        end
      end
      default: begin
        expect_result(TAG_NONE, 8'h00, 1'b0, 1'b1);
      end
    endcase
  endtask

  // literal text, first byte optionally opens a request
  task automatic add_text(input string s, input bit first);
    for (int i = 0; i < s.len(); i++) begin
      pending_bytes.push_back('{byte_t'(s[i]), first && i == 0, 1'b0});
    end
  endtask

  // keyword with letters in random case
  task automatic put_word(input string s);
    byte_t c;
    for (int i = 0; i < s.len(); i++) begin
      c = byte_t'(s[i]);
      if (c >= 8'h41 && c <= 8'h5a && $urandom_range(0, 1)) c = c | 8'h20;
      frame.push_back(c);
    end
  endtask

  // random field content that never holds the terminator
  task automatic put_field(input int n, input byte_t stop);
    byte_t c;
    repeat (n) begin
      do c = byte_t'($urandom_range(0, 255)); while (c == stop);
      frame.push_back(c);
    end
  endtask

  // one random request: mostly well formed, some spoilt, cut short or plain noise
  task automatic add_request(input bit sync);
    int    kind;
    int    proto_at;
    int    host_at;
    int    spot;
    byte_t mask;
    kind = $urandom_range(0, 19);
    frame.delete();
    if (kind < 2) begin
      repeat ($urandom_range(1, 6)) frame.push_back(byte_t'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 1)) put_word("GET ");
      else put_word("POST ");
      put_field(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8), CH_SPACE);
      frame.push_back(CH_SPACE);
      proto_at = frame.size();
      put_word("HTTP/");
      put_field($urandom_range(0, 4), CH_LF);
      if ($urandom_range(0, 1)) frame.push_back(CH_CR);
      frame.push_back(CH_LF);
      host_at = frame.size();
      put_word("HOST: ");
      put_field($urandom_range(0, 6), CH_LF);
      frame.push_back(CH_LF);
      if (kind < 7) begin
        // spoil one byte, mostly inside a keyword
        case ($urandom_range(0, 3))
          0:       spot = $urandom_range(0, 3);
          1:       spot = proto_at + $urandom_range(0, 4);
          2:       spot = host_at + $urandom_range(0, 5);
          default: spot = $urandom_range(0, frame.size() - 1);
        endcase
        do mask = byte_t'($urandom_range(1, 255)); while (mask == 8'h20);
        frame[spot] = frame[spot] ^ mask;
      end else if (kind == 7) begin
        // cut short, the next request starts mid header
        spot = $urandom_range(1, frame.size() - 1);
        while (frame.size() > spot) void'(frame.pop_back());
      end
      repeat ($urandom_range(0, 2)) frame.push_back(byte_t'($urandom_range(0, 255)));
    end
    for (int i = 0; i < frame.size(); i++) begin
      pending_bytes.push_back('{frame[i], i == 0 && kind != 8, sync && i == 0});
    end
  endtask

  // input side: offer items from the pending queue with random gaps
  always @(posedge clk) begin : drive_input
    header_byte_t nxt;
    int gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
      // parser mirror starts where the block leaves reset
      parse_at = AT_METHOD;
      match_idx = 0;
      cand = 2'b11;
      meth_now = METH_NONE;
      stat_now = ST_PROGRESS;
    end else begin
      if (in_valid && !in_stall) begin
        parse_header_byte(in_char_in, in_begin_req);
        items_taken <= items_taken + 1;
      end
      quiet_tail <= (pending_bytes.size() < 40);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() == 0 ||
                     (pending_bytes[0].sync_before && results_seen != results_due)) begin
          in_valid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else begin
          nxt = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_char_in <= nxt.ch;
          in_begin_req <= nxt.first;
        end
      end
    end
  end

  // result side: short stall bursts and one long hold-off
  always @(posedge clk) begin : drive_stall
    int  hold_left;
    bit  long_hold_done;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      long_hold_done = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && items_taken >= 150) begin
      long_hold_done = 1'b1;
      hold_left = 39;
      out_stall <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_result
    parse_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: tag %0d data %02h fend %0d method %0d status %0d last %0d",
                   out_tag, out_data, out_field_end, out_method, out_status, out_last);
      end else begin
        want = results_due_q.pop_front();
        results_seen <= results_seen + 1;
        if (out_tag !== want.tag || out_data !== want.data || out_field_end !== want.fend ||
            out_method !== want.meth || out_status !== want.stat || out_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected tag %0d data %02h fend %0d method %0d status %0d last %0d",
                     want.tag, want.data, want.fend, want.meth, want.stat, want.last);
            $display("          got      tag %0d data %02h fend %0d method %0d status %0d last %0d",
                     out_tag, out_data, out_field_end, out_method, out_status, out_last);
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    // lower case keywords, empty path, protocol and host
    add_text("get  http/\nhost: \n", 1'b1);
    // unsupported method, then a byte after parsing has ended
    add_text("x", 1'b1);
    pending_bytes.push_back('{8'hff, 1'b0, 1'b0});
    // extreme path bytes, then a broken protocol prefix
    add_text("PoSt ", 1'b1);
    pending_bytes.push_back('{8'h00, 1'b0, 1'b0});
    pending_bytes.push_back('{8'hff, 1'b0, 1'b0});
    pending_bytes.push_back('{CH_SPACE, 1'b0, 1'b0});
    add_text("HTX", 1'b0);
    for (int r = 0; pending_bytes.size() < 420; r++) add_request(r == 0 || r == 8);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || in_valid) @(negedge clk);
    while (results_seen != results_due) @(negedge clk);
    repeat (12) @(negedge clk);
    if (results_due_q.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", results_due_q.size());
    end
    $display("covered %0d header bytes giving %0d results", items_taken, results_seen);
    $display("headers: %0d complete, %0d unsupported method, %0d incomplete",
             n_complete, n_unsupported, n_incomplete);
    if (mismatches == 0) begin
      $display("tb_http_request_header_parser_core OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_http_request_header_parser_core NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout");
    $display("tb_http_request_header_parser_core NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
